[sv/ppi_slot_decoder_core_macros.svh]
// Assertion macros shared by the slot decoder RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef PPI_SLOT_DECODER_CORE_MACROS_SVH
`define PPI_SLOT_DECODER_CORE_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define PSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication.
`define PSD_ASSERT_IMPLY(label, ante, cons, msg) \
  `PSD_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define PSD_ASSERT_NEXT(label, ante, cons, msg) \
  `PSD_ASSERT(label, (ante) |=> (cons), msg)

`endif

[sv/psd_pkg.sv]
// Types, codes and helper functions for the slot decoder.
// Used by psd_decode, psd_ppi_regs and ppi_slot_decoder_core.
`timescale 1ns / 1ps

package psd_pkg;

  typedef enum logic [2:0] {
    TGT_NONE  = 3'd0,
    TGT_ROM   = 3'd1,
    TGT_RAM   = 3'd2,
    TGT_CARTA = 3'd3,
    TGT_CARTB = 3'd4,
    TGT_VDP   = 3'd5,
    TGT_PSG   = 3'd6,
    TGT_PPI   = 3'd7
  } psd_target_t;

  typedef enum logic [1:0] {
    PPI_PORT_A    = 2'd0,
    PPI_PORT_B    = 2'd1,
    PPI_PORT_C    = 2'd2,
    PPI_PORT_CTRL = 2'd3
  } psd_ppi_port_t;

  localparam logic [15:0] ADDR_SUBSLOT = 16'hFFFF;
  localparam logic [7:0]  IO_VDP_LO    = 8'h98;
  localparam logic [7:0]  IO_VDP_HI    = 8'h99;
  localparam logic [7:0]  IO_PSG_LO    = 8'hA0;
  localparam logic [7:0]  IO_PSG_HI    = 8'hA2;
  localparam logic [7:0]  IO_PPI_LO    = 8'hA8;
  localparam logic [7:0]  IO_PPI_HI    = 8'hAB;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 3;

  typedef struct packed {
    logic        opcode;       // 1 = I/O access
    logic [15:0] address;
    logic        write_enable;
    logic [7:0]  write_data;
    logic [7:0]  row_bits;
  } psd_req_t;

  typedef struct packed {
    psd_target_t target;
    logic [15:0] target_address;
    logic        write_strobe;
    logic [7:0]  read_data;
    logic [7:0]  control;      // port C after this access
  } psd_rsp_t;

  typedef struct packed {
    logic [7:0] slot;
    logic [7:0] control;
  } psd_state_t;

  typedef struct packed {
    logic       slot_we;
    logic       ctrl_we;
    logic [7:0] slot_d;
    logic [7:0] ctrl_d;
  } psd_upd_t;

  function automatic psd_target_t slot_target(input logic [1:0] sel);
    psd_target_t t;
    case (sel)
      2'd1:    t = TGT_RAM;
      2'd2:    t = TGT_CARTA;
      2'd3:    t = TGT_CARTB;
      default: t = TGT_NONE;
    endcase
    return t;
  endfunction

endpackage

[sv/psd_ppi_regs.sv]
// Port A (slot select) and port C (control) registers of the peripheral.
// Depends on psd_pkg for the update and state structs.
`timescale 1ns / 1ps

module psd_ppi_regs
  import psd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  psd_upd_t   upd,
  output psd_state_t state
);

  logic [7:0] slot_r;
  logic [7:0] ctrl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      ctrl_r <= '0;
    end else if (en) begin
      if (upd.slot_we) begin
        slot_r <= upd.slot_d;
      end
      if (upd.ctrl_we) begin
        ctrl_r <= upd.ctrl_d;
      end
    end
  end

  assign state.slot    = slot_r;
  assign state.control = ctrl_r;

endmodule

[sv/psd_decode.sv]
// Combinational decode of one bus access: memory slot routing, I/O port
// decode and peripheral register access. Depends on psd_pkg.
`timescale 1ns / 1ps

module psd_decode
  import psd_pkg::*;
(
  input  psd_req_t   req,
  input  psd_state_t state,
  output psd_rsp_t   rsp,
  output psd_upd_t   upd
);

  logic [1:0]  sel;
  logic [7:0]  port;
  logic [7:0]  bit_mask;
  logic        wr;
  psd_target_t tgt;
  logic [15:0] taddr;
  logic [7:0]  rd;

  assign wr       = req.write_enable;
  assign port     = req.address[7:0];
  assign sel      = state.slot[{req.address[15:14], 1'b0} +: 2];
  assign bit_mask = 8'(1) << req.write_data[3:1];

  always_comb begin
    tgt         = TGT_NONE;
    taddr       = '0;
    rd          = '0;
    upd.slot_we = 1'b0;
    upd.ctrl_we = 1'b0;
    upd.slot_d  = req.write_data;
    upd.ctrl_d  = req.write_data;
    if (!req.opcode) begin
      if (req.address == ADDR_SUBSLOT) begin
        tgt = slot_target(state.slot[7:6]);
      end else if (sel == 2'd0) begin
        // slot 0: ROM in the low half, RAM reads above, writes dropped
        if (!wr) begin
          tgt = req.address[15] ? TGT_RAM : TGT_ROM;
        end
      end else begin
        tgt = slot_target(sel);
      end
      if (tgt != TGT_NONE) begin
        taddr = req.address;
      end
    end else begin
      case (port) inside
        [IO_VDP_LO:IO_VDP_HI]: begin
          tgt   = TGT_VDP;
          taddr = 16'(port - IO_VDP_LO);
        end
        [IO_PSG_LO:IO_PSG_HI]: begin
          tgt   = TGT_PSG;
          taddr = 16'(port - IO_PSG_LO);
        end
        [IO_PPI_LO:IO_PPI_HI]: begin
          tgt   = TGT_PPI;
          taddr = 16'(port[1:0]);
          case (psd_ppi_port_t'(port[1:0]))
            PPI_PORT_A: begin
              if (wr) begin
                upd.slot_we = 1'b1;
              end else begin
                rd = state.slot;
              end
            end
            PPI_PORT_B: begin
              if (!wr) begin
                rd = req.row_bits;
              end
            end
            PPI_PORT_C: begin
              if (wr) begin
                upd.ctrl_we = 1'b1;
              end else begin
                rd = state.control;
              end
            end
            PPI_PORT_CTRL: begin
              // bit set/reset; mode-set commands (bit 7) are ignored
              if (wr && !req.write_data[7]) begin
                upd.ctrl_we = 1'b1;
                upd.ctrl_d  = req.write_data[0] ? (state.control | bit_mask)
                                                : (state.control & ~bit_mask);
              end
            end
            default: begin
              rd = '0;
            end
          endcase
        end
        default: begin
          tgt = TGT_NONE;
        end
      endcase
    end
  end

  assign rsp.target         = tgt;
  assign rsp.target_address = taddr;
  assign rsp.write_strobe   = wr && (tgt != TGT_NONE);
  assign rsp.read_data      = rd;
  assign rsp.control        = upd.ctrl_we ? upd.ctrl_d : state.control;

endmodule

[sv/ppi_slot_decoder_core.sv]
// Bus access decoder with primary slot selection through peripheral ports.
// Input channel (in_*): one bus access per transfer, opcode and write flag
//   in in_tuser, address, write data and keyboard row byte in in_tdata.
// Output channel (out_*): one result per access, target code in out_tuser,
//   routed address, write strobe, read data and port C controls in out_tdata.
// Path: an accepted access is captured in the input register, decoded
//   against the port A/C registers and loaded into the result register
//   once that register is free or being taken; out_tvalid is registered.
// Throughput: one access per cycle while out_tready stays high; decode is a
//   single shallow pass between the input register and the result register.
// Reset: synchronous, active low; clears both stages and port A and port C.
// Stall: while out_tready is low the result holds, one more access may wait
//   in the input register, then in_tready drops until the result leaves.
// Port A/C update as an access moves into the result register, so accesses
//   see the state left by all earlier ones in order.
// Depends on psd_pkg, psd_decode, psd_ppi_regs and the assertion macros.
`timescale 1ns / 1ps
`include "ppi_slot_decoder_core_macros.svh"

module ppi_slot_decoder_core
  import psd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] address, [23:16] write_data, [31:24] keyboard_row_bits
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] opcode, [1] write_enable
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] target_address, [16] write_strobe, [24:17] read_data,
  // [28:25] row_select, [29] cassette_motor, [30] cassette_out,
  // [31] caps_lamp, [32] click_sound, [39:33] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [2:0] target
  output logic [OUT_USER_W-1:0] out_tuser
);

  psd_req_t   req_r;
  logic       s1_valid_r;
  psd_rsp_t   rsp_r;
  logic       out_valid_r;
  psd_rsp_t   rsp_nxt;
  psd_upd_t   upd;
  psd_state_t state;
  logic       in_xfer;
  logic       advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_xfer || (s1_valid_r && !advance);
      out_valid_r <= advance || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r.opcode       <= in_tuser[0];
      req_r.write_enable <= in_tuser[1];
      req_r.address      <= in_tdata[15:0];
      req_r.write_data   <= in_tdata[23:16];
      req_r.row_bits     <= in_tdata[31:24];
    end
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  psd_decode u_decode (
    .req   (req_r),
    .state (state),
    .rsp   (rsp_nxt),
    .upd   (upd)
  );

  psd_ppi_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .upd   (upd),
    .state (state)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = rsp_r.target;
  assign out_tdata  = {7'd0, rsp_r.control, rsp_r.read_data, rsp_r.write_strobe,
                       rsp_r.target_address};

  `PSD_ASSERT_IMPLY(a_rd_only_ppi, out_valid_r && (rsp_r.read_data != 8'd0),
    rsp_r.target == TGT_PPI, "read data set for a non-peripheral target")
  `PSD_ASSERT_IMPLY(a_strobe_has_target, out_valid_r && rsp_r.write_strobe,
    rsp_r.target != TGT_NONE, "write strobe without a target")
  `PSD_ASSERT_IMPLY(a_io_offset_small,
    out_valid_r && (rsp_r.target == TGT_VDP || rsp_r.target == TGT_PSG ||
    rsp_r.target == TGT_PPI), rsp_r.target_address[15:2] == 14'd0,
    "I/O port offset out of range")
  `PSD_ASSERT_NEXT(a_in_captured, in_tvalid && in_tready, s1_valid_r,
    "accepted transfer not held in input register")
  `PSD_ASSERT_NEXT(a_regs_hold_idle, !advance, $stable(state),
    "peripheral registers changed without an access")

endmodule
